/* rtl/dual_motor_overcurrent_stall_monitor_unit_assert.svh */
// Assertion macros for the dual motor over-current and stall monitor.
// Include guard plus implication helpers; no other dependencies.
`ifndef DUAL_MOTOR_OVERCURRENT_STALL_MONITOR_UNIT_ASSERT_SVH
`define DUAL_MOTOR_OVERCURRENT_STALL_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DMOSM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmosm same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DMOSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmosm next-cycle check failed");

`endif

/* rtl/dmosm_pkg.sv */
// Package for the dual motor over-current and stall monitor.
// Field widths, register indexes, limits and magnitude helpers; no dependencies.
package dmosm_pkg;

  localparam int STEP_W    = 20;
  localparam int CUR_W     = 16;
  localparam int SPD_W     = 14;
  localparam int CUR_CFG_W = 15;
  localparam int TIMER_W   = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_CURRENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_CURRENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIMEOUT = 2'd2;

  localparam logic [CUR_CFG_W-1:0] TRIP_MIN      = 15'd1000;
  localparam logic [CUR_CFG_W-1:0] TRIP_MAX      = 15'd30000;
  localparam logic [CUR_CFG_W-1:0] STALL_CUR_MIN = 15'd500;
  localparam logic [TIMER_W-1:0]   TIMEOUT_MIN   = 22'd100000;
  localparam logic [TIMER_W-1:0]   TIMEOUT_MAX   = 22'd3000000;
  localparam logic [TIMER_W-1:0]   TIMER_MAX     = 22'h3FFFFF;
  localparam logic [SPD_W:0]       TARGET_MIN    = 15'd100;
  localparam logic [SPD_W:0]       SPEED_MAX     = 15'd25;

  typedef struct packed {
    logic [STEP_W-1:0]       step_us;
    logic                    fresh;
    logic                    hw_trip;
    logic signed [CUR_W-1:0] left_current_ma;
    logic signed [SPD_W-1:0] left_target_mms;
    logic signed [SPD_W-1:0] left_speed_mms;
    logic signed [CUR_W-1:0] right_current_ma;
    logic signed [SPD_W-1:0] right_target_mms;
    logic signed [SPD_W-1:0] right_speed_mms;
  } tick_t;

  function automatic logic [CUR_W:0] mag_cur(logic signed [CUR_W-1:0] v);
    logic [CUR_W:0] e;
    e = {v[CUR_W-1], v};
    return v[CUR_W-1] ? (~e + 1'b1) : e;
  endfunction

  function automatic logic [SPD_W:0] mag_spd(logic signed [SPD_W-1:0] v);
    logic [SPD_W:0] e;
    e = {v[SPD_W-1], v};
    return v[SPD_W-1] ? (~e + 1'b1) : e;
  endfunction

endpackage

/* rtl/dmosm_tick_if.sv */
// Request channel carrying one monitor tick per handshake.
// Depends on dmosm_pkg for field widths.
interface dmosm_tick_if;
  import dmosm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STEP_W-1:0]       step_us;
  logic                    fresh;
  logic                    hw_trip;
  logic signed [CUR_W-1:0] left_current_ma;
  logic signed [SPD_W-1:0] left_target_mms;
  logic signed [SPD_W-1:0] left_speed_mms;
  logic signed [CUR_W-1:0] right_current_ma;
  logic signed [SPD_W-1:0] right_target_mms;
  logic signed [SPD_W-1:0] right_speed_mms;

  modport source (
    output valid, step_us, fresh, hw_trip,
    output left_current_ma, left_target_mms, left_speed_mms,
    output right_current_ma, right_target_mms, right_speed_mms,
    input  ready
  );

  modport sink (
    input  valid, step_us, fresh, hw_trip,
    input  left_current_ma, left_target_mms, left_speed_mms,
    input  right_current_ma, right_target_mms, right_speed_mms,
    output ready
  );
endinterface

/* rtl/dmosm_report_if.sv */
// Result channel carrying one monitor report per handshake.
// Depends on dmosm_pkg for field widths.
interface dmosm_report_if;
  import dmosm_pkg::*;

  logic               valid;
  logic               ready;
  logic               settings_ok;
  logic               fresh_echo;
  logic               hw_trip_echo;
  logic               overcurrent;
  logic               stalled;
  logic [TIMER_W-1:0] left_stall_time_us;
  logic [TIMER_W-1:0] right_stall_time_us;

  modport source (
    output valid, settings_ok, fresh_echo, hw_trip_echo, overcurrent, stalled,
    output left_stall_time_us, right_stall_time_us,
    input  ready
  );

  modport sink (
    input  valid, settings_ok, fresh_echo, hw_trip_echo, overcurrent, stalled,
    input  left_stall_time_us, right_stall_time_us,
    output ready
  );
endinterface

/* rtl/dual_motor_overcurrent_stall_monitor_unit.sv */
// Top level of the dual motor over-current and stall monitor.
// Depends on dmosm_pkg, dmosm_tick_if, dmosm_report_if and the assertion header.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  tick     | sink      | step_us, fresh, hw_trip, currents/targets/speeds
//  report   | source    | settings_ok, echoes, overcurrent, stalled, timers
//  wr_*     | input     | register index and data, no handshake
//
// One tick request is taken per cycle while the report channel is not stalled; its report
// passes through the input register, then the result register holding the timer update.
// A stalled report register holds its request and backpressure reaches the
// tick channel only when both stages are full. Synchronous reset empties both
// stages and clears the settings and the two stall timers.
`include "dual_motor_overcurrent_stall_monitor_unit_assert.svh"

module dual_motor_overcurrent_stall_monitor_unit (
  input  logic                                clk,
  input  logic                                rst,
  dmosm_tick_if.sink                          tick,
  dmosm_report_if.source                      report,
  input  logic                                wr_en,
  input  logic [dmosm_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [dmosm_pkg::CFG_DAT_W-1:0]     wr_data
);
  import dmosm_pkg::*;

  logic [CUR_CFG_W-1:0] trip_current;
  logic [CUR_CFG_W-1:0] stall_current;
  logic [TIMER_W-1:0]   stall_timeout;
  logic [TIMER_W-1:0]   left_timer;
  logic [TIMER_W-1:0]   right_timer;

  tick_t  held;
  logic   held_valid;
  logic   out_free;
  logic   advance;
  logic   cfg_hit;

  logic               settings_ok;
  logic               run;
  logic               overcurrent_next;
  logic               stalled_next;
  logic               left_cond;
  logic               right_cond;
  logic [TIMER_W:0]   left_sum;
  logic [TIMER_W:0]   right_sum;
  logic [TIMER_W-1:0] left_timer_next;
  logic [TIMER_W-1:0] right_timer_next;

  assign out_free   = !report.valid || report.ready;
  assign advance    = held_valid && out_free;
  assign tick.ready = !held_valid || out_free;
  assign cfg_hit    = wr_en && (wr_index == CFG_TRIP_CURRENT ||
                                wr_index == CFG_STALL_CURRENT ||
                                wr_index == CFG_STALL_TIMEOUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      trip_current  <= '0;
      stall_current <= '0;
      stall_timeout <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TRIP_CURRENT:  trip_current  <= wr_data[CUR_CFG_W-1:0];
        CFG_STALL_CURRENT: stall_current <= wr_data[CUR_CFG_W-1:0];
        CFG_STALL_TIMEOUT: stall_timeout <= wr_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (tick.ready) begin
      held_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      held.step_us          <= tick.step_us;
      held.fresh            <= tick.fresh;
      held.hw_trip          <= tick.hw_trip;
      held.left_current_ma  <= tick.left_current_ma;
      held.left_target_mms  <= tick.left_target_mms;
      held.left_speed_mms   <= tick.left_speed_mms;
      held.right_current_ma <= tick.right_current_ma;
      held.right_target_mms <= tick.right_target_mms;
      held.right_speed_mms  <= tick.right_speed_mms;
    end
  end

  always_comb begin
    settings_ok = trip_current >= TRIP_MIN && trip_current <= TRIP_MAX &&
                  stall_current >= STALL_CUR_MIN && stall_current <= trip_current &&
                  stall_timeout >= TIMEOUT_MIN && stall_timeout <= TIMEOUT_MAX;
    run = settings_ok && held.fresh && !held.hw_trip && held.step_us != '0;

    left_cond  = mag_cur(held.left_current_ma) >= {2'b0, stall_current} &&
                 mag_spd(held.left_target_mms) >= TARGET_MIN &&
                 mag_spd(held.left_speed_mms) <= SPEED_MAX;
    right_cond = mag_cur(held.right_current_ma) >= {2'b0, stall_current} &&
                 mag_spd(held.right_target_mms) >= TARGET_MIN &&
                 mag_spd(held.right_speed_mms) <= SPEED_MAX;

    left_sum  = {1'b0, left_timer} + (TIMER_W + 1)'(held.step_us);
    right_sum = {1'b0, right_timer} + (TIMER_W + 1)'(held.step_us);

    left_timer_next  = '0;
    right_timer_next = '0;
    overcurrent_next = 1'b0;
    stalled_next      = 1'b0;
    if (run) begin
      if (left_cond) begin
        left_timer_next = left_sum[TIMER_W] ? TIMER_MAX : left_sum[TIMER_W-1:0];
      end
      if (right_cond) begin
        right_timer_next = right_sum[TIMER_W] ? TIMER_MAX : right_sum[TIMER_W-1:0];
      end
      overcurrent_next = mag_cur(held.left_current_ma) >= {2'b0, trip_current} ||
                         mag_cur(held.right_current_ma) >= {2'b0, trip_current};
      stalled_next = ({1'b0, left_timer_next} + 1'b1) >= {1'b0, stall_timeout} ||
                     ({1'b0, right_timer_next} + 1'b1) >= {1'b0, stall_timeout};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_timer  <= '0;
      right_timer <= '0;
    end else if (cfg_hit) begin
      left_timer  <= '0;
      right_timer <= '0;
    end else if (advance) begin
      left_timer  <= left_timer_next;
      right_timer <= right_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (out_free) begin
      report.valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      report.settings_ok         <= settings_ok;
      report.fresh_echo          <= held.fresh;
      report.hw_trip_echo        <= held.hw_trip;
      report.overcurrent         <= overcurrent_next;
      report.stalled             <= stalled_next;
      report.left_stall_time_us  <= left_timer_next;
      report.right_stall_time_us <= right_timer_next;
    end
  end

  `DMOSM_ASSERT_SAME(a_stall_needs_settings, clk, rst,
    report.valid && report.stalled, report.settings_ok)
  `DMOSM_ASSERT_SAME(a_blocked_clears_timers, clk, rst,
    report.valid && (!report.fresh_echo || report.hw_trip_echo),
    report.left_stall_time_us == '0 && report.right_stall_time_us == '0 && !report.stalled)
  `DMOSM_ASSERT_NEXT(a_write_clears_timers, clk, rst,
    cfg_hit, left_timer == '0 && right_timer == '0)

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for dual_motor_overcurrent_stall_monitor_unit: directed table, then random ticks,
// each report checked against the table's expected values or a local model of the timers and flags.
// Depends on dmosm_pkg, dmosm_tick_if and dmosm_report_if.
module testbench;
  import dmosm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic               settings_ok;
    logic               fresh_echo;
    logic               hw_trip_echo;
    logic               overcurrent;
    logic               stalled;
    logic [TIMER_W-1:0] left_stall_time_us;
    logic [TIMER_W-1:0] right_stall_time_us;
  } status_t;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    tick_t                tick;
    bit                   fixed;
    status_t              want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_DAT_W-1:0] wr_data;

  dmosm_tick_if   tick_if();
  dmosm_report_if report_if();

  dual_motor_overcurrent_stall_monitor_unit dut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_if),
    .report   (report_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  logic [CUR_CFG_W-1:0] trip_ma;
  logic [CUR_CFG_W-1:0] stall_ma;
  logic [TIMER_W-1:0]   timeout_us;
  logic [TIMER_W-1:0]   left_timer;
  logic [TIMER_W-1:0]   right_timer;
  status_t              pending[$];
  status_t              head;
  int                   errors;
  bit                   calm;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("FAIL dual_motor_overcurrent_stall_monitor_unit");
    $finish;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 38);
  endfunction

  function automatic int unsigned magnitude(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit settings_valid();
    return trip_ma >= TRIP_MIN && trip_ma <= TRIP_MAX &&
           stall_ma >= STALL_CUR_MIN && stall_ma <= trip_ma &&
           timeout_us >= TIMEOUT_MIN && timeout_us <= TIMEOUT_MAX;
  endfunction

  function automatic bit stalling(logic signed [CUR_W-1:0] cur,
                                  logic signed [SPD_W-1:0] target,
                                  logic signed [SPD_W-1:0] speed);
    return magnitude(cur) >= stall_ma && magnitude(target) >= TARGET_MIN &&
           magnitude(speed) <= SPEED_MAX;
  endfunction

  function automatic logic [TIMER_W-1:0] next_timer(logic [TIMER_W-1:0] timer, bit hit,
                                                   logic [STEP_W-1:0] step);
    int unsigned sum;
    if (!hit) return '0;
    sum = timer + step;
    return sum > TIMER_MAX ? TIMER_MAX : TIMER_W'(sum);
  endfunction

  // Advance both stall timers by one tick and build the report it produces.
  function automatic status_t monitor_tick(tick_t t);
    status_t s;
    s = '0;
    s.settings_ok  = settings_valid();
    s.fresh_echo   = t.fresh;
    s.hw_trip_echo = t.hw_trip;
    if (!s.settings_ok || !t.fresh || t.hw_trip || t.step_us == '0) begin
      left_timer  = '0;
      right_timer = '0;
    end else begin
      s.overcurrent = magnitude($signed(t.left_current_ma)) >= trip_ma ||
                      magnitude($signed(t.right_current_ma)) >= trip_ma;
      left_timer  = next_timer(left_timer, stalling($signed(t.left_current_ma),
                    $signed(t.left_target_mms), $signed(t.left_speed_mms)), t.step_us);
      right_timer = next_timer(right_timer, stalling($signed(t.right_current_ma),
                    $signed(t.right_target_mms), $signed(t.right_speed_mms)), t.step_us);
      s.stalled = left_timer + 32'd1 >= timeout_us || right_timer + 32'd1 >= timeout_us;
      s.left_stall_time_us  = left_timer;
      s.right_stall_time_us = right_timer;
    end
    return s;
  endfunction

  function automatic void pick_motor(output logic signed [CUR_W-1:0] cur,
                                     output logic signed [SPD_W-1:0] target,
                                     output logic signed [SPD_W-1:0] speed);
    int unsigned r;
    r = $urandom_range(99);
    cur    = CUR_W'($urandom_range(32768, stall_ma));
    target = SPD_W'($urandom_range(8192, 100));
    speed  = SPD_W'($urandom_range(25, 0));
    if (r >= 85) begin
      cur    = CUR_W'($urandom);
      target = SPD_W'($urandom);
      speed  = SPD_W'($urandom);
    end else if (r >= 80) begin
      cur = CUR_W'(int'(stall_ma) - 1);
    end else if (r >= 75) begin
      speed = 14'sd26;
    end else if (r >= 70) begin
      target = 14'sd99;
    end
    if ($urandom_range(1)) cur = -cur;
    if ($urandom_range(1)) target = -target;
    if ($urandom_range(1)) speed = -speed;
  endfunction

  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned r;
    r = $urandom_range(99);
    t.step_us = ($urandom_range(3) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(40000, 1));
    t.fresh   = 1'b1;
    t.hw_trip = 1'b0;
    if (r < 5) begin
      t.fresh = 1'b0;
    end else if (r < 10) begin
      t.hw_trip = 1'b1;
    end else if (r < 14) begin
      t.step_us = '0;
    end else if (r < 18) begin
      {t.fresh, t.hw_trip} = 2'($urandom);
    end
    pick_motor(t.left_current_ma, t.left_target_mms, t.left_speed_mms);
    pick_motor(t.right_current_ma, t.right_target_mms, t.right_speed_mms);
    return t;
  endfunction

  function automatic row_t tick_row(logic [STEP_W-1:0] step, bit fresh, bit hw_trip,
                                    logic signed [CUR_W-1:0] lc, logic signed [SPD_W-1:0] lt,
                                    logic signed [SPD_W-1:0] ls, logic signed [CUR_W-1:0] rc,
                                    logic signed [SPD_W-1:0] rt, logic signed [SPD_W-1:0] rs,
                                    bit fixed = 1'b0, status_t want = '0);
    row_t r;
    r.is_write = 1'b0;
    r.index    = '0;
    r.data     = '0;
    r.tick     = '{step, fresh, hw_trip, lc, lt, ls, rc, rt, rs};
    r.fixed    = fixed;
    r.want     = want;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    row_t r;
    r.is_write = 1'b1;
    r.index    = index;
    r.data     = data;
    r.tick     = '0;
    r.fixed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_tick(tick_t t, bit fixed, status_t want);
    status_t s;
    while (idle_now()) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
    end
    tick_if.step_us          <= t.step_us;
    tick_if.fresh            <= t.fresh;
    tick_if.hw_trip          <= t.hw_trip;
    tick_if.left_current_ma  <= t.left_current_ma;
    tick_if.left_target_mms  <= t.left_target_mms;
    tick_if.left_speed_mms   <= t.left_speed_mms;
    tick_if.right_current_ma <= t.right_current_ma;
    tick_if.right_target_mms <= t.right_target_mms;
    tick_if.right_speed_mms  <= t.right_speed_mms;
    tick_if.valid            <= 1'b1;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    s = monitor_tick(t);
    pending.push_back(fixed ? want : s);
  endtask

  // Drop valid and hold until every outstanding report is back.
  task automatic settle();
    tick_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    @(posedge clk);
    case (index)
      CFG_TRIP_CURRENT: begin
        trip_ma = data[CUR_CFG_W-1:0];
      end
      CFG_STALL_CURRENT: begin
        stall_ma = data[CUR_CFG_W-1:0];
      end
      CFG_STALL_TIMEOUT: begin
        timeout_us = data[TIMER_W-1:0];
      end
      default: begin
      end
    endcase
    if (index != CFG_SPARE) begin
      left_timer  = '0;
      right_timer = '0;
    end
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && report_if.valid && report_if.ready) begin
      if (pending.size() == 0) begin
        $error("report with no tick outstanding");
        errors++;
      end else begin
        head = pending.pop_front();
        check_field("settings_ok", head.settings_ok, report_if.settings_ok);
        check_field("fresh_echo", head.fresh_echo, report_if.fresh_echo);
        check_field("hw_trip_echo", head.hw_trip_echo, report_if.hw_trip_echo);
        check_field("overcurrent", head.overcurrent, report_if.overcurrent);
        check_field("stalled", head.stalled, report_if.stalled);
        check_field("left_stall_time_us", head.left_stall_time_us,
                    report_if.left_stall_time_us);
        check_field("right_stall_time_us", head.right_stall_time_us,
                    report_if.right_stall_time_us);
      end
    end
    report_if.ready <= !rst && !idle_now();
  end

  initial begin
    row_t                 rows[$];
    logic [CUR_CFG_W-1:0] trip;
    logic [CUR_CFG_W-1:0] stall;
    logic [TIMER_W-1:0]   limit;
    rst                      = 1'b1;
    wr_en                    = 1'b0;
    wr_index                 = '0;
    wr_data                  = '0;
    tick_if.valid            = 1'b0;
    tick_if.step_us          = '0;
    tick_if.fresh            = 1'b0;
    tick_if.hw_trip          = 1'b0;
    tick_if.left_current_ma  = '0;
    tick_if.left_target_mms  = '0;
    tick_if.left_speed_mms   = '0;
    tick_if.right_current_ma = '0;
    tick_if.right_target_mms = '0;
    tick_if.right_speed_mms  = '0;
    report_if.ready          = 1'b0;
    trip_ma                  = '0;
    stall_ma                 = '0;
    timeout_us               = '0;
    left_timer               = '0;
    right_timer              = '0;
    errors                   = 0;
    calm                     = 1'b0;

    rows.push_back(tick_row(20'hFFFFF, 1, 0, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{0, 1, 0, 0, 0, 0, 0}));
    rows.push_back(tick_row(20'd0, 0, 1, 0, 0, 0, 0, 0, 0, 1, status_t'{0, 0, 1, 0, 0, 0, 0}));
    rows.push_back(reg_row(CFG_TRIP_CURRENT, 22'd30000));
    rows.push_back(reg_row(CFG_STALL_CURRENT, 22'd500));
    rows.push_back(reg_row(CFG_STALL_TIMEOUT, 22'd100000));
    rows.push_back(tick_row(20'd0, 1, 0, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{1, 1, 0, 0, 0, 0, 0}));
    rows.push_back(tick_row(20'd5, 0, 0, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{1, 0, 0, 0, 0, 0, 0}));
    rows.push_back(tick_row(20'd5, 1, 1, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{1, 1, 1, 0, 0, 0, 0}));
    rows.push_back(tick_row(20'd1, 1, 0, 16'sh8000, 14'sh2000, -14'sd25,
                            16'sd32767, 14'sd8191, 14'sd25, 1, status_t'{1, 1, 0, 1, 0, 1, 1}));
    rows.push_back(tick_row(20'd99998, 1, 0, 16'sh8000, 14'sh2000, -14'sd25,
                            16'sd32767, 14'sd8191, 14'sd25, 1,
                            status_t'{1, 1, 0, 1, 1, 99999, 99999}));
    rows.push_back(reg_row(CFG_SPARE, 22'h3FFFFF));
    rows.push_back(tick_row(20'd1, 1, 0, 16'sh8000, 14'sh2000, -14'sd25,
                            16'sd32767, 14'sd8191, 14'sd25, 1,
                            status_t'{1, 1, 0, 1, 1, 100000, 100000}));
    repeat (3) begin
      rows.push_back(tick_row(20'hFFFFF, 1, 0, 16'sh8000, 14'sh2000, -14'sd25,
                              16'sd32767, 14'sd8191, 14'sd25));
    end
    rows.push_back(tick_row(20'hFFFFF, 1, 0, 16'sh8000, 14'sh2000, -14'sd25,
                            16'sd32767, 14'sd8191, 14'sd25, 1,
                            status_t'{1, 1, 0, 1, 1, TIMER_MAX, TIMER_MAX}));
    rows.push_back(tick_row(20'd10, 1, 0, 16'sd499, 14'sd8191, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd26));
    rows.push_back(tick_row(20'd10, 1, 0, 16'sd29999, 14'sd99, 14'sd0,
                            -16'sd30000, -14'sd100, -14'sd25));
    rows.push_back(tick_row(20'd7, 1, 0, 16'sd29999, 14'sd0, 14'sd0,
                            16'sd500, 14'sd100, 14'sd0));
    rows.push_back(reg_row(CFG_TRIP_CURRENT, 22'h3F83E8));
    rows.push_back(reg_row(CFG_STALL_CURRENT, 22'd1000));
    rows.push_back(reg_row(CFG_STALL_TIMEOUT, 22'd3000000));
    repeat (2) begin
      rows.push_back(tick_row(20'd1000000, 1, 0, 16'sd1000, 14'sd100, 14'sd25,
                              -16'sd999, 14'sd8191, 14'sd0));
    end
    rows.push_back(tick_row(20'd999999, 1, 0, 16'sd1000, 14'sd100, 14'sd25,
                            -16'sd999, 14'sd8191, 14'sd0));
    rows.push_back(reg_row(CFG_STALL_TIMEOUT, 22'd3000001));
    rows.push_back(tick_row(20'd5, 1, 0, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{0, 1, 0, 0, 0, 0, 0}));
    rows.push_back(reg_row(CFG_STALL_TIMEOUT, 22'd99999));
    rows.push_back(tick_row(20'd5, 1, 0, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{0, 1, 0, 0, 0, 0, 0}));
    rows.push_back(reg_row(CFG_STALL_TIMEOUT, 22'd100000));
    rows.push_back(reg_row(CFG_STALL_CURRENT, 22'd1001));
    rows.push_back(tick_row(20'd5, 1, 0, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{0, 1, 0, 0, 0, 0, 0}));
    rows.push_back(reg_row(CFG_STALL_CURRENT, 22'd500));
    rows.push_back(reg_row(CFG_TRIP_CURRENT, 22'd999));
    rows.push_back(tick_row(20'd5, 1, 0, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{0, 1, 0, 0, 0, 0, 0}));
    rows.push_back(reg_row(CFG_TRIP_CURRENT, 22'd30001));
    rows.push_back(tick_row(20'd5, 1, 0, 16'sh8000, 14'sh2000, 14'sd0,
                            16'sd32767, 14'sd8191, 14'sd0, 1, status_t'{0, 1, 0, 0, 0, 0, 0}));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        settle();
        set_reg(rows[i].index, rows[i].data);
      end else begin
        send_tick(rows[i].tick, rows[i].fixed, rows[i].want);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      calm  = (phase == 3);
      trip  = CUR_CFG_W'($urandom_range(30000, 1000));
      stall = CUR_CFG_W'($urandom_range(trip, 500));
      limit = TIMER_W'($urandom_range(3000000, 100000));
      if (phase == 5 || $urandom_range(5) == 0) begin
        case ($urandom_range(2))
          0: trip = CUR_CFG_W'($urandom);
          1: stall = CUR_CFG_W'($urandom);
          default: limit = TIMER_W'($urandom);
        endcase
      end
      set_reg(CFG_TRIP_CURRENT, {(CFG_DAT_W - CUR_CFG_W)'($urandom), trip});
      set_reg(CFG_STALL_CURRENT, {(CFG_DAT_W - CUR_CFG_W)'($urandom), stall});
      set_reg(CFG_STALL_TIMEOUT, limit);
      for (int n = 0; n < 125; n++) begin
        send_tick(random_tick(), 1'b0, '0);
        if (n == 62 && $urandom_range(1)) begin
          settle();
          set_reg(CFG_SPARE, CFG_DAT_W'($urandom));
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("PASS dual_motor_overcurrent_stall_monitor_unit");
    end else begin
      $display("FAIL dual_motor_overcurrent_stall_monitor_unit");
    end
    $finish;
  end

endmodule
